// ===== hdl/rbht_pkg.sv =====
package rbht_pkg;

  // Quotient bits resolved one per stage once overflow is ruled out
  localparam int QBITS = 31;
  // Divider depth: magnitude stage, overflow stage, one stage per quotient bit
  localparam int DIV_LAT = QBITS + 2;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_HIGH_X = 3'd3,
    REG_HIGH_Y = 3'd4,
    REG_HIGH_Z = 3'd5,
    REG_TOL    = 3'd6
  } reg_idx_t;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [QBITS-1:0] qmag;
    logic             ovf;
    logic             neg;
    logic             dzero;
  } div_res_t;

  typedef struct packed {
    vec3_t       org;
    vec3_t       dir;
    logic [31:0] tmin;
    logic [31:0] tmax;
  } side_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== hdl/rbht_div.sv =====
module rbht_div (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        bound,
  input  logic [31:0]        org,
  input  logic [31:0]        dir,
  output rbht_pkg::div_res_t res
);
  import rbht_pkg::*;

  logic [32:0] diff;
  logic [32:0] diff_neg;
  logic [31:0] a_nmag;
  logic [31:0] a_dmag;
  logic        a_neg;
  logic        a_dz;

  logic [31:0]      rem  [0:QBITS-1];
  logic [QBITS-1:0] num  [0:QBITS-1];
  logic [31:0]      dm   [0:QBITS-1];
  logic [QBITS-1:0] qq   [1:QBITS];
  logic             ovf  [0:QBITS];
  logic             neg  [0:QBITS];
  logic             dz   [0:QBITS];

  // Numerator magnitude (bound - origin) and divisor magnitude
  assign diff     = {bound[31], bound} - {org[31], org};
  assign diff_neg = ~diff + 33'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      a_nmag <= diff[32] ? diff_neg[31:0] : diff[31:0];
      a_dmag <= mag32(dir);
      a_neg  <= diff[32] ^ dir[31];
      a_dz   <= (dir == 32'd0);
    end
  end

  // Quotient reaches 2^31 exactly when the top numerator bits reach the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {15'd0, a_nmag[31:15]};
      num[0] <= {a_nmag[14:0], 16'd0};
      dm[0]  <= a_dmag;
      ovf[0] <= ({15'd0, a_nmag[31:15]} >= a_dmag);
      neg[0] <= a_neg;
      dz[0]  <= a_dz;
    end
  end

  // One restoring step per stage
  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [32:0] sh;
    logic [32:0] sub;
    logic        ge;

    assign sh  = {rem[k], num[k][QBITS-1]};
    assign sub = sh - {1'b0, dm[k]};
    assign ge  = (sh >= {1'b0, dm[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        ovf[k+1] <= ovf[k];
        neg[k+1] <= neg[k];
        dz[k+1]  <= dz[k];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          qq[1] <= {{(QBITS-1){1'b0}}, ge};
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          qq[k+1] <= {qq[k][QBITS-2:0], ge};
        end
      end
    end

    if (k < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? sub[31:0] : sh[31:0];
          num[k+1] <= {num[k][QBITS-2:0], 1'b0};
          dm[k+1]  <= dm[k];
        end
      end
    end
  end

  assign res.qmag  = qq[QBITS];
  assign res.ovf   = ovf[QBITS];
  assign res.neg   = neg[QBITS];
  assign res.dzero = dz[QBITS];

endmodule

// ===== hdl/rbht_inside.sv =====
module rbht_inside (
  input  logic            clk,
  input  logic            en,
  input  rbht_pkg::vec3_t org,
  input  rbht_pkg::vec3_t lo,
  input  rbht_pkg::vec3_t hi,
  input  logic [15:0]     tol,
  output logic            in_box
);
  import rbht_pkg::*;

  localparam logic [31:0] ONE = 32'h0001_0000;

  vec3_t             o1;
  vec3_t             o2;
  logic [2:0][31:0]  ml;
  logic [2:0][31:0]  mh;
  logic [2:0][47:0]  el;
  logic [2:0][47:0]  eh;
  logic [2:0]        in_ax;

  // Largest of |coord|, |bound| and one, per face
  always_ff @(posedge clk) begin
    if (en) begin
      o1 <= org;
      for (int a = 0; a < 3; a++) begin
        logic [31:0] cm, lm, hm, m0, m1;
        cm = mag32(org[a]);
        lm = mag32(lo[a]);
        hm = mag32(hi[a]);
        m0 = (cm > ONE) ? cm : ONE;
        m1 = (lm > m0) ? lm : m0;
        ml[a] <= m1;
        m1 = (hm > m0) ? hm : m0;
        mh[a] <= m1;
      end
    end
  end

  // Scale by the tolerance, exact at Q16.32
  always_ff @(posedge clk) begin
    if (en) begin
      o2 <= o1;
      for (int a = 0; a < 3; a++) begin
        el[a] <= ml[a] * {16'd0, tol};
        eh[a] <= mh[a] * {16'd0, tol};
      end
    end
  end

  // Compare the scaled origin against the widened faces
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [49:0] cs, lw, hw;
      cs = {{2{o2[a][31]}}, o2[a], 16'd0};
      lw = {{2{lo[a][31]}}, lo[a], 16'd0} - {2'd0, el[a]};
      hw = {{2{hi[a][31]}}, hi[a], 16'd0} + {2'd0, eh[a]};
      in_ax[a] = !(cs < lw) && !(cs > hw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_box <= &in_ax;
    end
  end

endmodule

// ===== hdl/ray_box_hit_test_unit.sv =====
// Ray segment versus axis-aligned box hit test, signed Q16.16.
// Input channel: in_valid/in_ready with origin, direction and the
// [param_min, param_max] window. Output channel: out_valid/out_ready with
// hit. The box corners and the inside tolerance are written over the APB
// port (byte address 4*i); the user must write them only while no item is
// in flight; the block does not enforce this. Path to a valid result on
// hit: the input register captures the item at the accepting edge, then a
// 33-stage divider (magnitude, overflow, one quotient bit per stage) for
// the face crossing parameter, three stages for saturation, multiplies and
// compares, and the output register. One item is accepted every cycle
// unless held. All stages advance together; when out_ready is low while a
// result is shown, the whole pipeline holds and in_ready drops, so nothing
// is lost or repeated. Bubbles travel as cleared valid bits.
// Synchronous reset clears all valid bits and sets the box registers and
// tolerance to zero; the pipeline is empty and ready right after reset.
module ray_box_hit_test_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic signed [31:0]            origin_z,
  input  logic signed [31:0]            dir_x,
  input  logic signed [31:0]            dir_y,
  input  logic signed [31:0]            dir_z,
  input  logic signed [31:0]            param_min,
  input  logic signed [31:0]            param_max,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbht_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rbht_pkg::*;

  logic        en;
  vec3_t       box_lo;
  vec3_t       box_hi;
  logic [15:0] tol;
  reg_idx_t    ridx;

  side_t       s1;
  logic        v1;
  side_t       side [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] vside;
  div_res_t    dres [0:2];

  vec3_t       p1_q;
  logic [2:0]  p1_nz;
  side_t       p1_s;
  logic        p1_v;

  logic [2:0]               p2_win;
  logic [2:0]               p2_nz;
  logic signed [63:0]       p2_pa [0:2];
  logic signed [63:0]       p2_pb [0:2];
  logic [2:0][32:0]         p2_dlo;
  logic [2:0][32:0]         p2_dhi;
  logic                     p2_v;

  logic [2:0]  p3_cross;
  logic        p3_v;
  logic        in_box;
  logic        box_bad;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;
  assign ridx     = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo <= '0;
      box_hi <= '0;
      tol    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_LOW_X:  box_lo[0] <= pwdata;
        REG_LOW_Y:  box_lo[1] <= pwdata;
        REG_LOW_Z:  box_lo[2] <= pwdata;
        REG_HIGH_X: box_hi[0] <= pwdata;
        REG_HIGH_Y: box_hi[1] <= pwdata;
        REG_HIGH_Z: box_hi[2] <= pwdata;
        REG_TOL:    tol       <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_LOW_X:  prdata = box_lo[0];
      REG_LOW_Y:  prdata = box_lo[1];
      REG_LOW_Z:  prdata = box_lo[2];
      REG_HIGH_X: prdata = box_hi[0];
      REG_HIGH_Y: prdata = box_hi[1];
      REG_HIGH_Z: prdata = box_hi[2];
      REG_TOL:    prdata = {16'd0, tol};
      default:    prdata = '0;
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.org  <= {origin_z, origin_y, origin_x};
      s1.dir  <= {dir_z, dir_y, dir_x};
      s1.tmin <= param_min;
      s1.tmax <= param_max;
    end
  end

  // One divider per axis, entry face chosen by direction sign
  for (genvar a = 0; a < 3; a++) begin : g_div
    rbht_div u_div (
      .clk   (clk),
      .en    (en),
      .bound (s1.dir[a][31] ? box_hi[a] : box_lo[a]),
      .org   (s1.org[a]),
      .dir   (s1.dir[a]),
      .res   (dres[a])
    );
  end

  // Carry the ray alongside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      vside <= '0;
    end else if (en) begin
      vside <= {vside[DIV_LAT-2:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= s1;
      for (int k = 1; k < DIV_LAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Signed quotient with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= vside[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_s <= side[DIV_LAT-1];
      for (int a = 0; a < 3; a++) begin
        logic [31:0] qm;
        qm = {1'b0, dres[a].qmag};
        if (dres[a].ovf) begin
          p1_q[a] <= dres[a].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          p1_q[a] <= dres[a].neg ? (~qm + 32'd1) : qm;
        end
        p1_nz[a] <= !dres[a].dzero;
      end
    end
  end

  // Window test, crossing point products, offsets to the faces
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_nz <= p1_nz;
      for (int a = 0; a < 3; a++) begin
        p2_win[a] <= ($signed(p1_q[a]) >= $signed(p1_s.tmin)) &&
                     ($signed(p1_q[a]) <= $signed(p1_s.tmax));
        p2_dlo[a] <= {box_lo[a][31], box_lo[a]} - {p1_s.org[a][31], p1_s.org[a]};
        p2_dhi[a] <= {box_hi[a][31], box_hi[a]} - {p1_s.org[a][31], p1_s.org[a]};
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_prod
    localparam int BA = (a + 1) % 3;
    localparam int BB = (a + 2) % 3;

    always_ff @(posedge clk) begin
      if (en) begin
        p2_pa[a] <= $signed(p1_s.dir[BA]) * $signed(p1_q[a]);
        p2_pb[a] <= $signed(p1_s.dir[BB]) * $signed(p1_q[a]);
      end
    end

    // Crossing point within the other two extents
    logic signed [63:0] lo_a, hi_a, lo_b, hi_b;
    assign lo_a = {{15{p2_dlo[BA][32]}}, p2_dlo[BA], 16'd0};
    assign hi_a = {{15{p2_dhi[BA][32]}}, p2_dhi[BA], 16'd0};
    assign lo_b = {{15{p2_dlo[BB][32]}}, p2_dlo[BB], 16'd0};
    assign hi_b = {{15{p2_dhi[BB][32]}}, p2_dhi[BB], 16'd0};

    always_ff @(posedge clk) begin
      if (en) begin
        p3_cross[a] <= p2_nz[a] && p2_win[a] &&
                       (p2_pa[a] >= lo_a) && (p2_pa[a] <= hi_a) &&
                       (p2_pb[a] >= lo_b) && (p2_pb[a] <= hi_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= p2_v;
    end
  end

  // Origin inside the widened box, aligned with the crossing result
  rbht_inside u_inside (
    .clk    (clk),
    .en     (en),
    .org    (side[DIV_LAT-1].org),
    .lo     (box_lo),
    .hi     (box_hi),
    .tol    (tol),
    .in_box (in_box)
  );

  always_comb begin
    box_bad = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if ($signed(box_lo[a]) > $signed(box_hi[a])) begin
        box_bad = 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= box_bad || in_box || (|p3_cross);
    end
  end

endmodule

// ===== tb/ray_box_hit_test_unit_checker.sv =====
module ray_box_hit_test_unit_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [31:0]          origin_x,
  input  logic signed [31:0]          origin_y,
  input  logic signed [31:0]          origin_z,
  input  logic signed [31:0]          dir_x,
  input  logic signed [31:0]          dir_y,
  input  logic signed [31:0]          dir_z,
  input  logic signed [31:0]          param_min,
  input  logic signed [31:0]          param_max,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        hit,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbht_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending_hits
);
  import rbht_pkg::*;

  localparam longint ONE = 65536;
  localparam longint S32_MAX = 64'sh7FFFFFFF;
  localparam longint S32_MIN = -64'sh80000000;

  longint box_lo [3];
  longint box_hi [3];
  longint eps;
  bit     hit_q [$];

  function automatic longint abs64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint max_of3(input longint a, input longint b, input longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  // Origin coordinate within the tolerance-widened extent of one axis
  function automatic bit within_axis(input longint c, input int a);
    longint el;
    longint eh;
    el = max_of3(abs64(c), abs64(box_lo[a]), ONE) * eps;
    eh = max_of3(abs64(c), abs64(box_hi[a]), ONE) * eps;
    if (c * ONE < box_lo[a] * ONE - el) return 0;
    if (c * ONE > box_hi[a] * ONE + eh) return 0;
    return 1;
  endfunction

  // Entry face crossed inside the window and inside the other two extents
  function automatic bit face_crossed(input int a, input longint o [3], input longint d [3],
                                      input longint tmin, input longint tmax);
    longint bound;
    longint q;
    longint p;
    if (d[a] == 0) return 0;
    bound = d[a] > 0 ? box_lo[a] : box_hi[a];
    q = ((bound - o[a]) * ONE) / d[a];
    if (q > S32_MAX) q = S32_MAX;
    if (q < S32_MIN) q = S32_MIN;
    if (q < tmin || q > tmax) return 0;
    for (int b = 0; b < 3; b++) begin
      if (b != a) begin
        p = d[b] * q + o[b] * ONE;
        if (p < box_lo[b] * ONE || p > box_hi[b] * ONE) return 0;
      end
    end
    return 1;
  endfunction

  function automatic bit predict_hit();
    longint o [3];
    longint d [3];
    bit h;
    o[0] = origin_x; o[1] = origin_y; o[2] = origin_z;
    d[0] = dir_x; d[1] = dir_y; d[2] = dir_z;
    h = 0;
    for (int a = 0; a < 3; a++)
      if (box_lo[a] > box_hi[a]) h = 1;
    if (!h && within_axis(o[0], 0) && within_axis(o[1], 1) && within_axis(o[2], 2)) h = 1;
    for (int a = 0; a < 3; a++)
      if (!h && face_crossed(a, o, d, param_min, param_max)) h = 1;
    return h;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] = 0;
        box_hi[a] = 0;
      end
      eps = 0;
      hit_q.delete();
      fail_count <= 0;
      pending_hits <= 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_LOW_X:  box_lo[0] = longint'($signed(pwdata));
          REG_LOW_Y:  box_lo[1] = longint'($signed(pwdata));
          REG_LOW_Z:  box_lo[2] = longint'($signed(pwdata));
          REG_HIGH_X: box_hi[0] = longint'($signed(pwdata));
          REG_HIGH_Y: box_hi[1] = longint'($signed(pwdata));
          REG_HIGH_Z: box_hi[2] = longint'($signed(pwdata));
          REG_TOL:    eps = longint'(pwdata[15:0]);
          default: ;
        endcase
      end
      // Compare the oldest expected hit
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          $error("hit: unexpected item, actual %0d", hit);
          fail_count <= fail_count + 1;
        end else begin
          if (hit !== hit_q[0]) begin
            $error("hit: expected %0d, actual %0d", hit_q[0], hit);
            fail_count <= fail_count + 1;
          end
          void'(hit_q.pop_front());
        end
      end
      if (in_valid && in_ready) hit_q.push_back(predict_hit());
      pending_hits <= hit_q.size();
    end
  end

endmodule

// ===== tb/ray_box_hit_test_unit_tb.sv =====
module ray_box_hit_test_unit_tb;
  import rbht_pkg::*;

  localparam int RAND_ITEMS = 1650;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic signed [31:0] dir_x, dir_y, dir_z;
  logic signed [31:0] param_min, param_max;
  logic               out_valid;
  logic               out_ready;
  logic               hit;
  logic               psel, penable, pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending_hits;
  int                 idle_cycles;
  bit                 long_hold;
  logic [31:0]        box [6];

  ray_box_hit_test_unit u_top (.*);

  ray_box_hit_test_unit_checker u_chk (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Receiver: own stall pattern, one long hold-off to fill the pipeline
  initial begin
    int hold;
    out_ready = 1'b0;
    @(negedge clk);
    while (1) begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 200) begin
          @(negedge clk);
          hold++;
        end
        long_hold = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx != REG_TOL) box[idx] = value;
  endtask

  task automatic set_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                         input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz,
                         input logic [31:0] eps);
    write_reg(REG_LOW_X, lx);
    write_reg(REG_LOW_Y, ly);
    write_reg(REG_LOW_Z, lz);
    write_reg(REG_HIGH_X, hx);
    write_reg(REG_HIGH_Y, hy);
    write_reg(REG_HIGH_Z, hz);
    write_reg(REG_TOL, eps);
  endtask

  // Offer one item and hold it until accepted
  task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                          input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
                          input logic [31:0] tlo, input logic [31:0] thi);
    in_valid <= 1'b1;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    param_min <= tlo; param_max <= thi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      4: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return 32'($signed($urandom_range(0, 4000)) - 2000) << 8;
    endcase
  endfunction

  // Point inside or near the box on one axis
  function automatic logic [31:0] near_box(input int a);
    longint lo;
    longint hi;
    lo = longint'($signed(box[a]));
    hi = longint'($signed(box[a + 3]));
    if (hi < lo || hi - lo > 64'd1000000000 || $urandom_range(0, 5) == 0) return rand_word();
    return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))) + $signed($urandom_range(0, 64)) - 32);
  endfunction

  task automatic random_phase(input int count);
    int sent;
    int burst;
    logic [31:0] o [3];
    logic [31:0] d [3];
    logic [31:0] t0, t1;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < count) begin
        for (int a = 0; a < 3; a++) begin
          o[a] = $urandom_range(0, 3) == 0 ? near_box(a) : 32'(rand_word());
          d[a] = $urandom_range(0, 5) == 0 ? 32'd0 : rand_word();
        end
        // Mostly aim at the box: direction from the origin toward a point in or near it
        if ($urandom_range(0, 2) != 0) begin
          for (int a = 0; a < 3; a++) begin
            o[a] = near_box(a);
            d[a] = 32'($signed(near_box(a)) - $signed(o[a]));
            o[a] = 32'($signed(o[a]) - $signed(d[a]));
          end
          t0 = 32'($signed($urandom_range(0, 131072)) - 65536);
          t1 = 32'($signed($urandom_range(0, 262144)));
        end else begin
          t0 = rand_word();
          t1 = $urandom_range(0, 7) == 0 ? rand_word() : 32'h7FFFFFFF;
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2], t0, t1);
        sent++;
        burst--;
      end
      in_valid <= 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    origin_x = '0; origin_y = '0; origin_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0;
    param_min = '0; param_max = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    long_hold = 0;
    for (int i = 0; i < 6; i++) box[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unit box with small tolerance
    set_box(32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 32'h00010000,
            32'h00010000, 32'd655);
    send_ray(0, 0, 0, 0, 0, 0, 0, 0);
    send_ray(32'h00010100, 0, 0, 0, 0, 0, 0, 0);
    send_ray(32'h00010400, 0, 0, 0, 0, 0, 0, 0);
    send_ray(32'hFFFB0000, 0, 0, 32'h00010000, 0, 0, 0, 32'h000A0000);
    send_ray(32'h00050000, 0, 0, 32'hFFFF0000, 0, 0, 0, 32'h000A0000);
    send_ray(32'hFFFB0000, 0, 0, 32'h00010000, 0, 0, 32'h000A0000, 0);
    send_ray(32'hFFFB0000, 0, 0, 32'h00010000, 0, 0, 32'h00040000, 32'h00040000);
    send_ray(32'hFFFB0000, 32'h00050000, 0, 32'h00010000, 0, 0, 0, 32'h000A0000);
    send_ray(0, 32'hFFFB0000, 0, 0, 32'h00010000, 0, 32'h80000000, 32'h7FFFFFFF);
    send_ray(0, 0, 32'h00050000, 0, 0, 32'hFFFF0000, 32'h80000000, 32'h7FFFFFFF);
    send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h00000001, 32'h7FFFFFFF,
             32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000001,
             32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_ray(32'h00050000, 0, 0, 32'h00010000, 0, 0, 32'h80000000, 32'h7FFFFFFF);
    drain();
    // Invalid box, maximal tolerance
    set_box(32'h00010000, 0, 0, 0, 0, 0, 32'hFFFF);
    send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0);
    send_ray(32'h00020000, 0, 0, 0, 0, 0, 0, 0);
    drain();
    // Whole range box, then zero tolerance
    set_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'd0);
    send_ray(32'h80000000, 32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF, 0,
             32'h80000000, 32'h7FFFFFFF);
    drain();

    // Random phases over several box settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_box(32'hFFFE0000, 32'hFFFD0000, 32'hFFFF8000, 32'h00020000, 32'h00010000,
                   32'h00030000, $urandom_range(0, 65535));
        1: set_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'hFFFF);
        2: set_box(32'h00100000, 32'h00100000, 32'h00100000, 32'h00100000, 32'h00100000,
                   32'h00100000, 0);
        3: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_box(32'hFFF60000, 32'hFFF60000, 32'h00000100, 32'h000A0000, 32'h000A0000,
                         32'h00050000, $urandom_range(0, 4000));
      endcase
      if (ph == 2) long_hold = 1;
      random_phase(RAND_ITEMS / 6);
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
